/* rtl/hcbd_pkg.sv */
// Package for the chunked body decoder: item type between front and back,
// character codes and sizing constants. No dependencies.
package hcbd_pkg;

  localparam int unsigned SizeBitsDefault = 32;
  localparam int unsigned HexDigitBits    = 4;   // one hex digit, radix 16
  localparam int unsigned QueueDepth      = 2;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // Classified body byte, as queued between front and back.
  typedef struct packed {
    logic [7:0]              data;
    logic                    is_cr;
    logic                    is_lf;
    logic                    is_hex;
    logic [HexDigitBits-1:0] hex_val;
  } hcbd_item_t;

endpackage

/* rtl/http_chunked_body_decoder.sv */
// Top level of the HTTP chunked body decoder: front, queue and back joined.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue, hcbd_back.
//
//   channel  direction  handshake                  payload
//   in       in         in_valid_i / in_stall_o    in_byte_i
//   out      out        out_valid_o / out_stall_i  accepted_o, payload_valid_o,
//                                                  payload_byte_o, msg_done_o,
//                                                  msg_error_o
//   cfg      in         cfg_we_i                   cfg_wdata_i (payload_enable)
//
// One byte per cycle sustained while the output does not stall; each byte yields
// one result, through the queue write, then the state update into the result register.
// The framing state machine in the back end updates once per popped byte and sets
// that rate. Reset is asynchronous, active low: size line phase, counters and
// flags cleared, payload enabled, queue empty. A stall on the output holds the
// result register; the two-entry queue absorbs the byte in flight and
// in_stall_o rises only once it is full. After done or error, bytes are still
// transferred but reported with accepted_o low and no state change.
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = SizeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic       msg_done_o,
  output logic       msg_error_o
);

  hcbd_item_t push_item, pop_item;
  logic       q_push, q_full, q_pop, q_valid;

  // classify incoming bytes and hand them to the queue
  hcbd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  hcbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // framing state machine and result register
  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_item_i        (pop_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accepted_o      (accepted_o),
    .payload_valid_o (payload_valid_o),
    .payload_byte_o  (payload_byte_o),
    .msg_done_o      (msg_done_o),
    .msg_error_o     (msg_error_o)
  );

  // a byte is refused only once the message has ended or failed
  a_refused_needs_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (msg_done_o || msg_error_o))
    else $error("byte refused without done or error");

  // a payload byte never ends the message or flags an error
  a_payload_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (accepted_o && !msg_done_o && !msg_error_o))
    else $error("payload byte with done or error");

  // a new result needs a queued byte in the cycle before
  a_result_from_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(q_valid))
    else $error("result without queued byte");

  // the queue never takes a byte while full
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (!q_full && !in_stall_o))
    else $error("queue overrun");

endmodule

/* rtl/hcbd_front.sv */
// Front end of the chunked body decoder: input handshake and byte classify.
// Depends on hcbd_pkg.
module hcbd_front import hcbd_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output hcbd_item_t q_item_o
);

  logic is_dec, is_lc, is_uc;

  assign is_dec = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign is_lc  = (in_byte_i >= 8'h61) && (in_byte_i <= 8'h66);
  assign is_uc  = (in_byte_i >= 8'h41) && (in_byte_i <= 8'h46);

  always_comb begin
    q_item_o.data    = in_byte_i;
    q_item_o.is_cr   = (in_byte_i == ChCr);
    q_item_o.is_lf   = (in_byte_i == ChLf);
    q_item_o.is_hex  = is_dec || is_lc || is_uc;
    // letters: low nibble 1..6 maps to 10..15
    if (is_dec) begin
      q_item_o.hex_val = in_byte_i[HexDigitBits-1:0];
    end else begin
      q_item_o.hex_val = in_byte_i[HexDigitBits-1:0] + 4'd9;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

/* rtl/hcbd_queue.sv */
// Small FIFO of classified bytes between front and back.
// Depends on hcbd_pkg.
module hcbd_queue import hcbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hcbd_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output hcbd_item_t item_o
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  hcbd_item_t            mem_q [QueueDepth];
  logic [IdxW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/hcbd_back.sv */
// Back end of the chunked body decoder: framing state machine, size counters,
// payload enable register and the result register. Depends on hcbd_pkg.
module hcbd_back import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = SizeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       q_valid_i,
  input  hcbd_item_t q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic       msg_done_o,
  output logic       msg_error_o
);

  localparam logic [2:0] PhSize   = 3'd0;
  localparam logic [2:0] PhData   = 3'd1;
  localparam logic [2:0] PhDataCr = 3'd2;
  localparam logic [2:0] PhDataLf = 3'd3;
  localparam logic [2:0] PhTrlCr  = 3'd4;
  localparam logic [2:0] PhTrlLf  = 3'd5;

  logic [2:0]           phase_q, phase_d;
  logic [SIZE_BITS-1:0] size_q, size_d, left_q, left_d, left_dec;
  logic                 seen_q, seen_d, done_q, done_d, err_q, err_d;
  logic                 pen_q;
  logic                 acc, pv;
  logic                 out_valid_q;
  logic                 acc_q, pv_q, done_out_q, err_out_q;
  logic [7:0]           pbyte_q, pb;

  assign q_pop_o  = q_valid_i && (!out_valid_q || !out_stall_i);
  assign left_dec = (left_q != '0) ? left_q - 1'b1 : '0;

  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    left_d  = left_q;
    seen_d  = seen_q;
    done_d  = done_q;
    err_d   = err_q;
    acc     = 1'b0;
    pv      = 1'b0;
    pb      = '0;
    if (!done_q && !err_q) begin
      acc = 1'b1;
      case (phase_q)
        PhData: begin
          if (pen_q) begin
            pv = 1'b1;
            pb = q_item_i.data;
          end
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PhDataCr;
          end
        end
        PhDataCr: begin
          if (q_item_i.is_cr) begin
            phase_d = PhDataLf;
          end else if (q_item_i.is_lf) begin
            phase_d = PhSize;
          end else begin
            err_d = 1'b1;
          end
        end
        PhDataLf: begin
          if (q_item_i.is_lf) begin
            phase_d = PhSize;
          end else begin
            err_d = 1'b1;
          end
        end
        PhTrlCr: begin
          if (q_item_i.is_cr) begin
            phase_d = PhTrlLf;
          end else if (q_item_i.is_lf) begin
            done_d = 1'b1;
          end
        end
        PhTrlLf: begin
          if (q_item_i.is_lf) begin
            done_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        default: begin
          // size line; unused codes fall back here
          phase_d = PhSize;
          if (q_item_i.is_cr) begin
            phase_d = PhSize;
          end else if (q_item_i.is_lf) begin
            if (!seen_q) begin
              err_d = 1'b1;
            end else begin
              left_d  = size_q;
              size_d  = '0;
              seen_d  = 1'b0;
              phase_d = (size_q == '0) ? PhTrlCr : PhData;
            end
          end else if (!q_item_i.is_hex) begin
            err_d = 1'b1;
          end else if (size_q[SIZE_BITS-1 -: HexDigitBits] != '0) begin
            err_d = 1'b1;  // next digit would overflow
          end else begin
            size_d = {size_q[SIZE_BITS-HexDigitBits-1:0], q_item_i.hex_val};
            seen_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSize;
      size_q      <= '0;
      left_q      <= '0;
      seen_q      <= 1'b0;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      pen_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pen_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        phase_q <= phase_d;
        size_q  <= size_d;
        left_q  <= left_d;
        seen_q  <= seen_d;
        done_q  <= done_d;
        err_q   <= err_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      acc_q      <= acc;
      pv_q       <= pv;
      pbyte_q    <= pb;
      done_out_q <= done_d;
      err_out_q  <= err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign payload_valid_o = pv_q;
  assign payload_byte_o  = pbyte_q;
  assign msg_done_o      = done_out_q;
  assign msg_error_o     = err_out_q;

endmodule

/* dv/tb_http_chunked_body_decoder.sv */
// Self-checking testbench for http_chunked_body_decoder: chunked byte streams,
// payload enable changes and random stalls on both channels.
// Depends on hcbd_pkg and the decoder RTL only.
module tb_http_chunked_body_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam int unsigned SB = SizeBitsDefault;

  // Framing position as tracked by the predictor.
  typedef enum logic [2:0] {
    SizeLine, ChunkData, DataCr, DataLf, TrailerCr, TrailerLf
  } frame_phase_e;

  // How the single message of the run is closed (the decoder never restarts).
  typedef enum int {
    EndTrailerCrlf, EndBareLf, EndNonHex, EndEmptyLine,
    EndBadTerm, EndOverflow, EndTrailerNoLf, EndHugeChunk
  } msg_end_e;

  typedef struct packed {
    logic       accepted;
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic       done;
    logic       msg_err;
  } decode_result_t;

  // Tracks the decoder framing state and keeps the results still owed.
  class chunk_scoreboard;
    frame_phase_e   phase;
    logic [SB-1:0]  size_acc;
    logic [SB-1:0]  chunk_left;
    bit             seen_digit;
    bit             done_flag;
    bit             err_flag;
    bit             pay_en;
    decode_result_t pending_results[$];
    int unsigned    mismatches;

    function new();
      phase      = SizeLine;
      size_acc   = '0;
      chunk_left = '0;
      seen_digit = 1'b0;
      done_flag  = 1'b0;
      err_flag   = 1'b0;
      pay_en     = 1'b1;
      mismatches = 0;
    endfunction

    static function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
    endfunction

    function void note_cfg(logic v);
      pay_en = v;
    endfunction

    // One accepted input byte: advance the framing state, queue its result.
    function void decode_byte(logic [7:0] c);
      decode_result_t r;
      int             d;
      r = '0;
      if (!done_flag && !err_flag) begin
        r.accepted = 1'b1;
        case (phase)
          ChunkData: begin
            if (pay_en) begin
              r.pay_valid = 1'b1;
              r.pay_byte  = c;
            end
            if (chunk_left != 0) chunk_left--;
            if (chunk_left == 0) phase = DataCr;
          end
          DataCr: begin
            if (c == ChCr) phase = DataLf;
            else if (c == ChLf) phase = SizeLine;
            else err_flag = 1'b1;
          end
          DataLf: begin
            if (c == ChLf) phase = SizeLine;
            else err_flag = 1'b1;
          end
          TrailerCr: begin
            // trailer text is skipped; only CR or LF matter here
            if (c == ChCr) phase = TrailerLf;
            else if (c == ChLf) done_flag = 1'b1;
          end
          TrailerLf: begin
            if (c == ChLf) done_flag = 1'b1;
            else err_flag = 1'b1;
          end
          default: begin
            phase = SizeLine;
            d = hex_digit(c);
            if (c == ChLf) begin
              if (!seen_digit) begin
                err_flag = 1'b1;
              end else begin
                chunk_left = size_acc;
                size_acc   = '0;
                seen_digit = 1'b0;
                phase      = (chunk_left == 0) ? TrailerCr : ChunkData;
              end
            end else if (c != ChCr) begin  // CR in the size line is ignored
              if (d < 0) err_flag = 1'b1;
              else if (size_acc[SB-1 -: HexDigitBits] != 0) err_flag = 1'b1;
              else begin
                size_acc   = {size_acc[SB-HexDigitBits-1:0], d[HexDigitBits-1:0]};
                seen_digit = 1'b1;
              end
            end
          end
        endcase
      end
      r.done    = done_flag;
      r.msg_err = err_flag;
      pending_results.push_back(r);
    endfunction

    function void check_result(decode_result_t got);
      decode_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result with none expected: acc=%0b pv=%0b pb=%02h done=%0b err=%0b",
                   $realtime, got.accepted, got.pay_valid, got.pay_byte, got.done,
                   got.msg_err);
        return;
      end
      want = pending_results.pop_front();
      if (got.accepted !== want.accepted || got.pay_valid !== want.pay_valid ||
          got.pay_byte !== want.pay_byte || got.done !== want.done ||
          got.msg_err !== want.msg_err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: mismatch exp acc=%0b pv=%0b pb=%02h done=%0b err=%0b,",
                   $realtime, want.accepted, want.pay_valid, want.pay_byte, want.done,
                   want.msg_err,
                   " got acc=%0b pv=%0b pb=%02h done=%0b err=%0b",
                   got.accepted, got.pay_valid, got.pay_byte, got.done,
                   got.msg_err);
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  // Clock, reset and DUT inputs, all known from time zero.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic       accepted_o;
  logic       payload_valid_o;
  logic [7:0] payload_byte_o;
  logic       msg_done_o;
  logic       msg_error_o;

  // Idle rates in percent; the receiver also takes one-off long hold requests.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned bytes_sent    = 0;

  chunk_scoreboard sb = new();

  always #4 clk_i = ~clk_i;

  http_chunked_body_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accepted_o      (accepted_o),
    .payload_valid_o (payload_valid_o),
    .payload_byte_o  (payload_byte_o),
    .msg_done_o      (msg_done_o),
    .msg_error_o     (msg_error_o)
  );

  // Monitor: everything is sampled at the clock edge, before the NBA updates
  // of that edge, so register writes, input transfers and output transfers
  // are seen exactly as the DUT sees them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.note_cfg(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.decode_byte(in_byte_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result('{accepted_o, payload_valid_o, payload_byte_o,
                          msg_done_o, msg_error_o});
    end
  end

  // Receiver: random stall at the current rate, or a long hold when asked.
  // The hold is counted here so the sender keeps offering bytes meanwhile and
  // the input queue fills up.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one byte and return at the edge where it transfers. Valid stays
  // high into the next call, so back-to-back bytes get one NBA per step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Sender pause: drop valid and wait until every owed result has come back.
  // The first edge lets the monitor log the byte that just transferred.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Register write, only issued with the decoder idle.
  task automatic write_payload_enable(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hex digit in random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (chunk_scoreboard::hex_digit(b) >= 0 || b == ChCr || b == ChLf);
    return b;
  endfunction

  // Size line: optional leading zeros, stray CRs, then LF.
  task automatic send_size(input logic [31:0] n, input int unsigned zeros);
    int unsigned nd;
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    repeat (zeros) send_byte("0");
    for (int i = int'(nd) - 1; i >= 0; i--) begin
      if ($urandom_range(0, 15) == 0) send_byte(ChCr);
      send_byte(hex_char(n[4*i +: 4]));
    end
    if ($urandom_range(0, 1)) send_byte(ChCr);
    send_byte(ChLf);
  endtask

  // Well-formed chunk with random data and a CRLF or bare LF terminator.
  task automatic send_chunk(input int unsigned n);
    send_size(n, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) != 0) send_byte(ChCr);
    send_byte(ChLf);
  endtask

  // Mostly short chunks, some longer ones.
  task automatic send_chunks(input int unsigned budget);
    int unsigned stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at)
      send_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(21, 64)
                                             : $urandom_range(1, 20));
  endtask

  // Close the message one way or another; afterwards nothing is consumed.
  task automatic send_message_end(input msg_end_e kind);
    int unsigned n;
    case (kind)
      EndTrailerCrlf: begin
        send_size(0, $urandom_range(0, 2));
        repeat ($urandom_range(0, 12)) send_byte(non_hex_byte());
        send_byte(ChCr);
        send_byte(ChLf);
      end
      EndBareLf: begin
        send_size(0, 0);
        send_byte(ChLf);
      end
      EndNonHex: begin
        repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15))));
        send_byte(non_hex_byte());
      end
      EndEmptyLine: begin
        if ($urandom_range(0, 1)) send_byte(ChCr);
        send_byte(ChLf);
      end
      EndBadTerm: begin
        n = $urandom_range(1, 8);
        send_size(n, 0);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_byte(ChCr);
        send_byte(non_hex_byte());
      end
      EndOverflow: begin
        // leading zeros are harmless; the ninth significant digit overflows
        repeat ($urandom_range(0, 3)) send_byte("0");
        send_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (8) send_byte(hex_char(4'($urandom_range(0, 15))));
      end
      EndTrailerNoLf: begin
        send_size(0, 0);
        repeat ($urandom_range(0, 6)) send_byte(non_hex_byte());
        send_byte(ChCr);
        send_byte(non_hex_byte());
      end
      default: begin
        // largest size the counter holds; the chunk never completes
        send_size(32'hFFFF_FFFF, $urandom_range(0, 1));
        repeat ($urandom_range(4, 16)) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat ($urandom_range(4, 10)) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_payload_enable(1'b1);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 15;
    recv_idle_pct = 73;

    // Directed: bare LF size line and terminator, byte 00.
    send_byte("1"); send_byte(ChLf); send_byte(8'h00); send_byte(ChLf);
    // Leading zero, CRLF everywhere, a data byte that looks like framing.
    send_byte("0"); send_byte("2"); send_byte(ChCr); send_byte(ChLf);
    send_byte(8'hFF); send_byte(ChCr); send_byte(ChCr); send_byte(ChLf);
    // As many leading zeros as the counter has digits, CR between digits.
    repeat (4) send_byte("0");
    send_byte(ChCr);
    repeat (4) send_byte("0");
    send_byte("1"); send_byte(ChLf); send_byte(ChLf); send_byte(ChLf);

    send_chunks(130);
    drain_results();
    write_payload_enable(1'b0);

    // Roles swapped, payload discarded.
    send_idle_pct = 73;
    recv_idle_pct = 15;
    send_chunks(130);
    drain_results();
    write_payload_enable(1'b1);

    // No idling; a long receiver hold backs the queue up into the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 64;
    send_chunks(130);
    send_message_end(msg_end_e'($urandom_range(0, int'(EndHugeChunk))));

    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
